// ===== hw/rtl/qts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the quad trapezoid splitter.
// Used by the channel interfaces, the multiplier and the top level.
package qts_pkg;

  // field widths
  localparam int unsigned XW        = 32;
  localparam int unsigned YW        = 16;
  localparam int unsigned ZW        = 32;
  localparam int unsigned SW        = 16;
  localparam int unsigned OSW       = 8;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_OFFSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_SCALE  = 1'd1;
  localparam logic [CFG_W-1:0]     DEPTH_SCALE_RST  = 32'h0001_0000;

  // edge kinds
  localparam logic KIND_SPLIT = 1'b0;
  localparam logic KIND_FAR   = 1'b1;

  // divider sizes: dividend 2*|d*num|+|den|, divisor 2*|den|
  localparam int unsigned DIV_NUM_W = 50;
  localparam int unsigned DIV_DEN_W = 17;
  localparam int unsigned MUL_W     = 32;

  // vertex store: bank 0 holds loaded corners, bank 1 the working copy
  localparam int unsigned RAM_DEPTH = 8;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic [ZW-1:0] z;
    logic [SW-1:0] s;
  } corner_t;

  localparam int unsigned CORNER_W = $bits(corner_t);

  typedef struct packed {
    logic [YW-1:0]  row;
    logic           edge_kind;
    logic [XW-1:0]  left_x;
    logic [XW-1:0]  right_x;
    logic [ZW-1:0]  left_z;
    logic [ZW-1:0]  right_z;
    logic [OSW-1:0] left_shade;
    logic [OSW-1:0] right_shade;
    logic           quad_done;
  } result_t;

  // round an 8.8 shade to an integer, saturate at 255
  function automatic logic [OSW-1:0] shade_out(input logic [SW-1:0] s);
    logic [SW:0] t;
    t = {1'b0, s} + 17'h00080;
    return t[SW] ? 8'hFF : t[SW-1:8];
  endfunction

  function automatic result_t mk_res(input logic [YW-1:0] row, input logic kind,
                                     input corner_t l, input corner_t r);
    result_t o;
    o.row         = row;
    o.edge_kind   = kind;
    o.left_x      = l.x;
    o.right_x     = r.x;
    o.left_z      = l.z;
    o.right_z     = r.z;
    o.left_shade  = shade_out(l.s);
    o.right_shade = shade_out(r.s);
    o.quad_done   = 1'b0;
    return o;
  endfunction

endpackage

// ===== hw/rtl/qts_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for vertex input and trapezoid edge output.
// Depends on qts_pkg for field widths.
interface qts_vertex_if;
  logic                   valid;
  logic                   ready;
  logic [qts_pkg::XW-1:0] vertex_x;
  logic [qts_pkg::YW-1:0] vertex_y;
  logic [qts_pkg::ZW-1:0] vertex_z;
  logic [qts_pkg::SW-1:0] vertex_shade;
  logic                   vertex_last;

  modport source (output valid, vertex_x, vertex_y, vertex_z, vertex_shade, vertex_last,
                  input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, vertex_shade, vertex_last,
                output ready);
endinterface

interface qts_result_if;
  logic                    valid;
  logic                    ready;
  logic [qts_pkg::YW-1:0]  row;
  logic                    edge_kind;
  logic [qts_pkg::XW-1:0]  left_x;
  logic [qts_pkg::XW-1:0]  right_x;
  logic [qts_pkg::ZW-1:0]  left_z;
  logic [qts_pkg::ZW-1:0]  right_z;
  logic [qts_pkg::OSW-1:0] left_shade;
  logic [qts_pkg::OSW-1:0] right_shade;
  logic                    quad_done;

  modport source (output valid, row, edge_kind, left_x, right_x, left_z, right_z,
                  left_shade, right_shade, quad_done, input ready);
  modport sink (input valid, row, edge_kind, left_x, right_x, left_z, right_z,
                left_shade, right_shade, quad_done, output ready);
endinterface

// ===== hw/rtl/qts_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/qts_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on qts_pkg for the operand width.
module qts_mul (
  input  logic                        clk_i,
  input  logic [qts_pkg::MUL_W-1:0]   a_i,
  input  logic [qts_pkg::MUL_W-1:0]   b_i,
  output logic [2*qts_pkg::MUL_W-1:0] p_o
);

  logic [2*qts_pkg::MUL_W-1:0] p_q;

  // register the product every cycle
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/qts_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; widths come from parameters.
module qts_div #(
  parameter int unsigned NUM_W = 50,
  parameter int unsigned DEN_W = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] acc_q, acc_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // one restoring step
  always_comb begin
    trial = {rem_q, acc_q[NUM_W-1]};
    ge    = trial >= {1'b0, den_q};
  end

  always_comb begin
    acc_d  = acc_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d  = num_i;
      rem_d  = '0;
      cnt_d  = CNT_W'(NUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      acc_d = {acc_q[NUM_W-2:0], ge};
      rem_d = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

// ===== hw/rtl/quad_trapezoid_splitter_core.sv =====
`timescale 1ns / 1ps
// Top level of the quad trapezoid splitter: sequencer, vertex store and output stage.
// Depends on qts_pkg, qts_if, qts_ram, qts_mul and qts_div.
//
//  channel  | dir | handshake    | payload
//  ---------+-----+--------------+------------------------------------------
//  vtx_i    | in  | valid/ready  | vertex_x, vertex_y, vertex_z, vertex_shade, vertex_last
//  res_o    | out | valid/ready  | row, edge_kind, left/right x z shade, quad_done
//  cfg      | in  | cfg_we_i     | cfg_idx_i, cfg_data_i (depth offset, depth scale)
//
// A vertex that is not the last passes through accept, depth multiply and store write.
// A last vertex then adds a copy sweep into the working bank and a search for the lowest
// corner, then per walk step a fetch of the four walk corners and 2 skip checks (again for
// each horizontal edge skipped), and per split three interpolations (none when the split
// row meets a corner), each on the 50-step shared divider; a quad yields up to three trapezoids.
// Reset clears the sequencer and sets depth_scale to 1.0; the vertex store has no reset.
// A stalled result output holds the sequencer only in S_EMITP, S_EMIT0 and its final state.
module quad_trapezoid_splitter_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  qts_vertex_if.sink                        vtx_i,
  qts_result_if.source                      res_o,
  input  logic                              cfg_we_i,
  input  logic [qts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [qts_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned RAW = $clog2(qts_pkg::RAM_DEPTH);

  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_ZMUL   = 16'h0002,
    S_ZWR    = 16'h0004,
    S_COPY   = 16'h0008,
    S_MINY   = 16'h0010,
    S_FETCH  = 16'h0020,
    S_SKIPF  = 16'h0040,
    S_SKIPB  = 16'h0080,
    S_DECIDE = 16'h0100,
    S_LMUL   = 16'h0200,
    S_LDIV   = 16'h0400,
    S_LWAIT  = 16'h0800,
    S_EMITP  = 16'h1000,
    S_EMIT0  = 16'h2000,
    S_EMIT1  = 16'h4000,
    S_FIN    = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [1:0]                 load_cnt_q, load_cnt_d;
  logic [qts_pkg::CFG_W-1:0]  off_q, off_d, scale_q, scale_d;
  logic [2:0]                 k_q, k_d;
  logic [1:0]                 cf_q, cf_d, nx_q, nx_d, cb_q, cb_d, pv_q, pv_d;
  logic [1:0]                 vi_q, vi_d;
  logic [1:0]                 traps_q, traps_d;
  logic                       pend_v_q, pend_v_d;
  logic                       out_v_q, out_v_d;

  // payload registers
  qts_pkg::corner_t           vin_q, vin_d;
  logic                       last_q, last_d;
  logic [qts_pkg::ZW-1:0]     zdiff_q, zdiff_d;
  logic                       zzero_q, zzero_d;
  logic [qts_pkg::YW-1:0]     ys_q [4];
  logic [qts_pkg::YW-1:0]     ys_d [4];
  qts_pkg::corner_t           rf_q, rf_d, rn_q, rn_d, rb_q, rb_d, rp_q, rp_d;
  qts_pkg::corner_t           la_q, la_d, lb_q, lb_d, bp_q, bp_d;
  logic                       bwd_q, bwd_d, bra_q, bra_d;
  logic                       neg_q, neg_d, den0_q, den0_d;
  logic [31:0]                a_q, a_d;
  logic [15:0]                den_mag_q, den_mag_d;
  qts_pkg::result_t           pend_q, pend_d, out_q, out_d;

  // unit connections
  logic                       ram_we;
  logic [RAW-1:0]             ram_waddr, ram_raddr;
  logic [qts_pkg::CORNER_W-1:0] ram_wdata, ram_rdata;
  qts_pkg::corner_t           rd_c;
  logic [qts_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [2*qts_pkg::MUL_W-1:0] mul_p;
  logic                       div_start, div_done;
  logic [qts_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [qts_pkg::DIV_DEN_W-1:0] div_den;

  // datapath helpers
  logic [31:0]  a_sel, b_sel, dmag, maxv, lerp_v;
  logic [32:0]  d33;
  logic [16:0]  num17, den17;
  logic [15:0]  nmag, dnmag;
  logic [qts_pkg::DIV_NUM_W-1:0] a50, sum50;
  logic [64:0]  rnd65;
  logic [31:0]  zs;
  logic [1:0]   kprev;
  logic         slot_free;
  qts_pkg::result_t r0, r1;
  logic [15:0]  y01, y23;
  logic [1:0]   m01, m23, mi;

  assign rd_c = qts_pkg::corner_t'(ram_rdata);

  qts_ram #(
    .WIDTH (qts_pkg::CORNER_W),
    .DEPTH (qts_pkg::RAM_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  qts_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  qts_div #(
    .NUM_W (qts_pkg::DIV_NUM_W),
    .DEN_W (qts_pkg::DIV_DEN_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // select the value being interpolated and form magnitudes and signs
  always_comb begin
    case (vi_q)
      2'd0: begin
        a_sel = la_q.x;
        b_sel = lb_q.x;
      end
      2'd1: begin
        a_sel = la_q.z;
        b_sel = lb_q.z;
      end
      default: begin
        a_sel = {16'h0000, la_q.s};
        b_sel = {16'h0000, lb_q.s};
      end
    endcase
    d33   = {1'b0, b_sel} - {1'b0, a_sel};
    dmag  = d33[32] ? (~d33[31:0] + 32'd1) : d33[31:0];
    num17 = {1'b0, bp_q.y} - {1'b0, la_q.y};
    nmag  = num17[16] ? (~num17[15:0] + 16'd1) : num17[15:0];
    den17 = {1'b0, lb_q.y} - {1'b0, la_q.y};
    dnmag = den17[16] ? (~den17[15:0] + 16'd1) : den17[15:0];
  end

  // round-to-nearest quotient applied to the start value, then clamped
  always_comb begin
    maxv  = (vi_q == 2'd2) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    a50   = {18'h0, a_q};
    sum50 = a50 + div_quo;
    if (den0_q) begin
      lerp_v = a_q;
    end else if (neg_q) begin
      lerp_v = (div_quo > a50) ? 32'h0 : (a_q - div_quo[31:0]);
    end else begin
      lerp_v = (sum50 > {18'h0, maxv}) ? maxv : sum50[31:0];
    end
  end

  // divider operands
  assign div_num = {mul_p[48:0], 1'b0} + {34'h0, den_mag_q};
  assign div_den = {den_mag_q, 1'b0};

  // depth scaling result
  always_comb begin
    rnd65 = {1'b0, mul_p} + 65'h8000;
    if (zzero_q) begin
      zs = 32'h0;
    end else if (|rnd65[64:48]) begin
      zs = 32'hFFFF_FFFF;
    end else begin
      zs = rnd65[47:16];
    end
  end

  // minimum-y corner
  always_comb begin
    m01 = (ys_q[0] < ys_q[1]) ? 2'd0 : 2'd1;
    y01 = (ys_q[0] < ys_q[1]) ? ys_q[0] : ys_q[1];
    m23 = (ys_q[2] < ys_q[3]) ? 2'd2 : 2'd3;
    y23 = (ys_q[2] < ys_q[3]) ? ys_q[2] : ys_q[3];
    mi  = (y01 > y23) ? m23 : m01;
  end

  // the split-edge and far-edge results of the current trapezoid
  always_comb begin
    if (bra_q) begin
      if (bwd_q) begin
        r0 = qts_pkg::mk_res(bp_q.y, qts_pkg::KIND_SPLIT, rp_q, bp_q);
        r1 = qts_pkg::mk_res(rf_q.y, qts_pkg::KIND_FAR, rb_q, rf_q);
      end else begin
        r0 = qts_pkg::mk_res(bp_q.y, qts_pkg::KIND_SPLIT, bp_q, rp_q);
        r1 = qts_pkg::mk_res(rf_q.y, qts_pkg::KIND_FAR, rf_q, rb_q);
      end
    end else begin
      if (bwd_q) begin
        r0 = qts_pkg::mk_res(bp_q.y, qts_pkg::KIND_SPLIT, bp_q, rn_q);
        r1 = qts_pkg::mk_res(rb_q.y, qts_pkg::KIND_FAR, rb_q, rf_q);
      end else begin
        r0 = qts_pkg::mk_res(bp_q.y, qts_pkg::KIND_SPLIT, rn_q, bp_q);
        r1 = qts_pkg::mk_res(rb_q.y, qts_pkg::KIND_FAR, rf_q, rb_q);
      end
    end
  end

  assign slot_free = !out_v_q || res_o.ready;
  assign kprev     = k_q[1:0] - 2'd1;

  // sequencer
  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    off_d      = off_q;
    scale_d    = scale_q;
    k_d        = k_q;
    cf_d       = cf_q;
    nx_d       = nx_q;
    cb_d       = cb_q;
    pv_d       = pv_q;
    vi_d       = vi_q;
    traps_d    = traps_q;
    pend_v_d   = pend_v_q;
    vin_d      = vin_q;
    last_d     = last_q;
    zdiff_d    = zdiff_q;
    zzero_d    = zzero_q;
    ys_d       = ys_q;
    rf_d       = rf_q;
    rn_d       = rn_q;
    rb_d       = rb_q;
    rp_d       = rp_q;
    la_d       = la_q;
    lb_d       = lb_q;
    bp_d       = bp_q;
    bwd_d      = bwd_q;
    bra_d      = bra_q;
    neg_d      = neg_q;
    den0_d     = den0_q;
    a_d        = a_q;
    den_mag_d  = den_mag_q;
    pend_d     = pend_q;
    out_d      = out_q;
    out_v_d    = res_o.ready ? 1'b0 : out_v_q;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = bp_q;
    ram_raddr  = '0;
    mul_a      = dmag;
    mul_b      = {16'h0000, nmag};
    div_start  = 1'b0;

    // register writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        qts_pkg::CFG_DEPTH_OFFSET: off_d   = cfg_data_i;
        qts_pkg::CFG_DEPTH_SCALE:  scale_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      S_IDLE: begin
        // take a vertex and prepare its depth
        if (vtx_i.valid) begin
          vin_d.x = vtx_i.vertex_x;
          vin_d.y = vtx_i.vertex_y;
          vin_d.z = vtx_i.vertex_z;
          vin_d.s = vtx_i.vertex_shade;
          last_d  = vtx_i.vertex_last;
          zzero_d = vtx_i.vertex_z <= off_q;
          zdiff_d = vtx_i.vertex_z - off_q;
          state_d = S_ZMUL;
        end
      end
      S_ZMUL: begin
        mul_a   = zdiff_q;
        mul_b   = scale_q;
        state_d = S_ZWR;
      end
      S_ZWR: begin
        // store the corner with its scaled depth
        ram_we    = 1'b1;
        ram_waddr = {1'b0, load_cnt_q};
        ram_wdata = {vin_q.x, vin_q.y, zs, vin_q.s};
        if (last_q) begin
          load_cnt_d = 2'd0;
          k_d        = 3'd0;
          state_d    = S_COPY;
        end else begin
          load_cnt_d = load_cnt_q + 2'd1;
          state_d    = S_IDLE;
        end
      end
      S_COPY: begin
        // copy the loaded corners into the working bank
        ram_raddr = {1'b0, k_q[1:0]};
        if (k_q != 3'd0) begin
          ram_we          = 1'b1;
          ram_waddr       = {1'b1, kprev};
          ram_wdata       = ram_rdata;
          ys_d[kprev]     = rd_c.y;
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          state_d = S_MINY;
        end
      end
      S_MINY: begin
        cf_d     = mi;
        cb_d     = mi;
        nx_d     = mi + 2'd1;
        pv_d     = mi - 2'd1;
        traps_d  = 2'd0;
        pend_v_d = 1'b0;
        k_d      = 3'd0;
        state_d  = S_FETCH;
      end
      S_FETCH: begin
        // read the four walk corners
        case (k_q[1:0])
          2'd0:    ram_raddr = {1'b1, cf_q};
          2'd1:    ram_raddr = {1'b1, nx_q};
          2'd2:    ram_raddr = {1'b1, cb_q};
          default: ram_raddr = {1'b1, pv_q};
        endcase
        if (k_q != 3'd0) begin
          case (kprev)
            2'd0:    rf_d = rd_c;
            2'd1:    rn_d = rd_c;
            2'd2:    rb_d = rd_c;
            default: rp_d = rd_c;
          endcase
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) begin
          k_d     = 3'd0;
          state_d = S_SKIPF;
        end
      end
      S_SKIPF: begin
        // skip a horizontal edge going forward
        if (rf_q.y == rn_q.y) begin
          if (nx_q == cb_q) begin
            state_d = S_FIN;
          end else begin
            cf_d    = nx_q;
            nx_d    = nx_q + 2'd1;
            state_d = S_FETCH;
          end
        end else begin
          state_d = S_SKIPB;
        end
      end
      S_SKIPB: begin
        // skip a horizontal edge going backward
        if (rb_q.y == rp_q.y) begin
          if (cf_q == pv_q) begin
            state_d = S_FIN;
          end else begin
            cb_d    = pv_q;
            pv_d    = pv_q - 2'd1;
            state_d = S_FETCH;
          end
        end else begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // pick the edge to split and the split row
        bwd_d = (rp_q.x < rn_q.x) || (rb_q.x < rf_q.x);
        bra_d = rp_q.y <= rn_q.y;
        vi_d  = 2'd0;
        if (rp_q.y <= rn_q.y) begin
          la_d   = rf_q;
          lb_d   = rn_q;
          bp_d.y = rp_q.y;
          if (rp_q.y == rn_q.y) begin
            bp_d    = rn_q;
            state_d = S_EMITP;
          end else begin
            state_d = S_LMUL;
          end
        end else begin
          la_d    = rb_q;
          lb_d    = rp_q;
          bp_d.y  = rn_q.y;
          state_d = S_LMUL;
        end
      end
      S_LMUL: begin
        // multiply |b - a| by |num|, keep signs and the divisor
        a_d       = a_sel;
        neg_d     = d33[32] ^ num17[16] ^ den17[16];
        den_mag_d = dnmag;
        den0_d    = den17 == 17'h0;
        state_d   = S_LDIV;
      end
      S_LDIV: begin
        if (den0_q) begin
          state_d = S_LWAIT;
        end else begin
          div_start = 1'b1;
          state_d   = S_LWAIT;
        end
      end
      S_LWAIT: begin
        // write the interpolated value into the split corner
        if (den0_q || div_done) begin
          case (vi_q)
            2'd0:    bp_d.x = lerp_v;
            2'd1:    bp_d.z = lerp_v;
            default: bp_d.s = lerp_v[15:0];
          endcase
          if (vi_q == 2'd2) begin
            state_d = S_EMITP;
          end else begin
            vi_d    = vi_q + 2'd1;
            state_d = S_LMUL;
          end
        end
      end
      S_EMITP: begin
        // release the held far edge of the previous trapezoid
        if (!pend_v_q) begin
          state_d = S_EMIT0;
        end else if (slot_free) begin
          out_d    = pend_q;
          out_v_d  = 1'b1;
          pend_v_d = 1'b0;
          state_d  = S_EMIT0;
        end
      end
      S_EMIT0: begin
        if (slot_free) begin
          out_d   = r0;
          out_v_d = 1'b1;
          state_d = S_EMIT1;
        end
      end
      S_EMIT1: begin
        // hold the far edge, update the working corner, advance the walk
        pend_d    = r1;
        pend_v_d  = 1'b1;
        ram_we    = 1'b1;
        ram_wdata = bp_q;
        traps_d   = traps_q + 2'd1;
        k_d       = 3'd0;
        if (bra_q) begin
          ram_waddr = {1'b1, cf_q};
          cb_d      = pv_q;
          pv_d      = pv_q - 2'd1;
          state_d   = ((cf_q == pv_q) || (traps_q == 2'd2)) ? S_FIN : S_FETCH;
        end else begin
          ram_waddr = {1'b1, cb_q};
          cf_d      = nx_q;
          nx_d      = nx_q + 2'd1;
          state_d   = ((nx_q == cb_q) || (traps_q == 2'd2)) ? S_FIN : S_FETCH;
        end
      end
      S_FIN: begin
        // last edge of the quad carries the done flag
        if (!pend_v_q) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          out_d           = pend_q;
          out_d.quad_done = 1'b1;
          out_v_d         = 1'b1;
          pend_v_d        = 1'b0;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      load_cnt_q <= 2'd0;
      off_q      <= '0;
      scale_q    <= qts_pkg::DEPTH_SCALE_RST;
      k_q        <= 3'd0;
      cf_q       <= 2'd0;
      nx_q       <= 2'd0;
      cb_q       <= 2'd0;
      pv_q       <= 2'd0;
      vi_q       <= 2'd0;
      traps_q    <= 2'd0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      off_q      <= off_d;
      scale_q    <= scale_d;
      k_q        <= k_d;
      cf_q       <= cf_d;
      nx_q       <= nx_d;
      cb_q       <= cb_d;
      pv_q       <= pv_d;
      vi_q       <= vi_d;
      traps_q    <= traps_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vin_q     <= vin_d;
    last_q    <= last_d;
    zdiff_q   <= zdiff_d;
    zzero_q   <= zzero_d;
    ys_q      <= ys_d;
    rf_q      <= rf_d;
    rn_q      <= rn_d;
    rb_q      <= rb_d;
    rp_q      <= rp_d;
    la_q      <= la_d;
    lb_q      <= lb_d;
    bp_q      <= bp_d;
    bwd_q     <= bwd_d;
    bra_q     <= bra_d;
    neg_q     <= neg_d;
    den0_q    <= den0_d;
    a_q       <= a_d;
    den_mag_q <= den_mag_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  // ports
  assign vtx_i.ready       = state_q == S_IDLE;
  assign res_o.valid       = out_v_q;
  assign res_o.row         = out_q.row;
  assign res_o.edge_kind   = out_q.edge_kind;
  assign res_o.left_x      = out_q.left_x;
  assign res_o.right_x     = out_q.right_x;
  assign res_o.left_z      = out_q.left_z;
  assign res_o.right_z     = out_q.right_z;
  assign res_o.left_shade  = out_q.left_shade;
  assign res_o.right_shade = out_q.right_shade;
  assign res_o.quad_done   = out_q.quad_done;

  // no held far edge survives the end of a quad
  a_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_v_q)
    else $error("held edge left behind at idle");

  // the divider finishes only while the sequencer waits on it
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_LWAIT)
    else $error("divider result arrived outside its wait state");

  // the copy sweep writes only the working bank
  a_copy_bank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COPY && ram_we) |-> ram_waddr[RAW-1])
    else $error("copy sweep wrote the load bank");

endmodule

// ===== tb/quad_trapezoid_splitter_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of quad_trapezoid_splitter_core: a directed table of corners,
// then random quads under several depth settings, checked against a built-in predictor.
// Depends on qts_pkg, qts_if and the RTL of the block.
module quad_trapezoid_splitter_core_tb;

  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 900;
  localparam int unsigned LONG_HOLD = 2500;
  localparam int unsigned ITEMS_PER_PHASE = 75;

  typedef struct {
    logic [qts_pkg::XW-1:0] x;
    logic [qts_pkg::YW-1:0] y;
    logic [qts_pkg::ZW-1:0] z;
    logic [qts_pkg::SW-1:0] s;
    logic                   last;
  } vertex_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [qts_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [qts_pkg::CFG_W-1:0] cfg_data_i;

  qts_vertex_if vtx ();
  qts_result_if res ();

  quad_trapezoid_splitter_core u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vtx_i     (vtx),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // predictor state
  qts_pkg::corner_t          corner_store[4];
  logic [3:0]                corner_written;
  int unsigned               corner_slot;
  logic [qts_pkg::CFG_W-1:0] depth_offset;
  logic [qts_pkg::CFG_W-1:0] depth_scale;
  qts_pkg::result_t          expected_edges[$];

  int unsigned errors;
  int unsigned edges_checked;
  int unsigned vertices_sent;
  int unsigned quads_split;
  int unsigned cycle_count;
  int          idle_mode;       // 0 none, 1 sender, 2 receiver, 3 both
  bit          long_hold_req;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d edges still expected", cycle_count,
               expected_edges.size());
      $display("quad_trapezoid_splitter_core_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [qts_pkg::ZW-1:0] scaled_depth(input logic [qts_pkg::ZW-1:0] z);
    longint unsigned p;
    if (z <= depth_offset) return '0;
    p = longint'(z - depth_offset) * longint'(depth_scale);
    p = (p + 64'h8000) >> 16;
    return (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
  endfunction

  // a + (b - a) * num / den, rounded half away from zero, clamped to [0, maxv]
  function automatic longint interp(input longint a, input longint b, input int num,
                                    input int den, input longint maxv);
    longint p, v, mag, q;
    if (den == 0) return a;
    p = (b - a) * longint'(num);
    if (den < 0) begin
      den = -den;
      p = -p;
    end
    mag = (p < 0) ? -p : p;
    q = (2 * mag + longint'(den)) / (2 * longint'(den));
    v = (p < 0) ? a - q : a + q;
    if (v < 0) return 0;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic qts_pkg::corner_t point_on_edge(input qts_pkg::corner_t a,
                                                     input qts_pkg::corner_t b,
                                                     input logic [qts_pkg::YW-1:0] row);
    qts_pkg::corner_t r;
    int num, den;
    num = int'(row) - int'(a.y);
    den = int'(b.y) - int'(a.y);
    r.x = 32'(interp(longint'(a.x), longint'(b.x), num, den, 64'hFFFF_FFFF));
    r.z = 32'(interp(longint'(a.z), longint'(b.z), num, den, 64'hFFFF_FFFF));
    r.s = 16'(interp(longint'(a.s), longint'(b.s), num, den, 64'hFFFF));
    r.y = row;
    return r;
  endfunction

  function automatic logic [qts_pkg::OSW-1:0] shade_to_int(input logic [qts_pkg::SW-1:0] s);
    int v;
    v = (int'(s) + 'h80) >> 8;
    return (v > 255) ? 8'hFF : v[7:0];
  endfunction

  function automatic qts_pkg::result_t edge_between(input logic [qts_pkg::YW-1:0] row,
                                                    input logic kind,
                                                    input qts_pkg::corner_t l,
                                                    input qts_pkg::corner_t r);
    qts_pkg::result_t e;
    e.row = row;
    e.edge_kind = kind;
    e.left_x = l.x;
    e.right_x = r.x;
    e.left_z = l.z;
    e.right_z = r.z;
    e.left_shade = shade_to_int(l.s);
    e.right_shade = shade_to_int(r.s);
    e.quad_done = 1'b0;
    return e;
  endfunction

  // walk the stored loop and queue the trapezoid edges it yields
  task automatic split_into_edges();
    qts_pkg::corner_t w[4];
    qts_pkg::corner_t bp;
    int mi, mj, nx, pv, cf, cb, traps;
    bit done, bwd_left;
    qts_pkg::result_t e0, e1;
    w = corner_store;
    traps = 0;
    done = 0;
    mi = (w[0].y < w[1].y) ? 0 : 1;
    mj = (w[2].y < w[3].y) ? 2 : 3;
    if (w[mi].y > w[mj].y) mi = mj;
    nx = (mi + 1) & 3;
    pv = (mi + 3) & 3;
    cf = mi;
    cb = mi;
    while (!done && traps < 3) begin
      // skip horizontal edges on both sides
      while (w[cf].y == w[nx].y) begin
        done = (nx == cb);
        if (done) break;
        cf = nx;
        nx = (cf + 1) & 3;
      end
      while (w[cb].y == w[pv].y) begin
        done = (cf == pv);
        if (done) break;
        cb = pv;
        pv = (cb + 3) & 3;
      end
      if (done) break;
      bwd_left = (w[pv].x < w[nx].x) || (w[cb].x < w[cf].x);
      if (w[pv].y <= w[nx].y) begin
        bp = (w[pv].y != w[nx].y) ? point_on_edge(w[cf], w[nx], w[pv].y) : w[nx];
        if (bwd_left) begin
          e0 = edge_between(bp.y, qts_pkg::KIND_SPLIT, w[pv], bp);
          e1 = edge_between(w[cf].y, qts_pkg::KIND_FAR, w[cb], w[cf]);
        end else begin
          e0 = edge_between(bp.y, qts_pkg::KIND_SPLIT, bp, w[pv]);
          e1 = edge_between(w[cf].y, qts_pkg::KIND_FAR, w[cf], w[cb]);
        end
        w[cf] = bp;
        cb = pv;
        pv = (cb + 3) & 3;
      end else begin
        bp = point_on_edge(w[cb], w[pv], w[nx].y);
        if (bwd_left) begin
          e0 = edge_between(bp.y, qts_pkg::KIND_SPLIT, bp, w[nx]);
          e1 = edge_between(w[cb].y, qts_pkg::KIND_FAR, w[cb], w[cf]);
        end else begin
          e0 = edge_between(bp.y, qts_pkg::KIND_SPLIT, w[nx], bp);
          e1 = edge_between(w[cb].y, qts_pkg::KIND_FAR, w[cf], w[cb]);
        end
        w[cb] = bp;
        cf = nx;
        nx = (cf + 1) & 3;
      end
      traps++;
      done = (cf == cb);
      e1.quad_done = done || traps == 3;
      expected_edges.push_back(e0);
      expected_edges.push_back(e1);
    end
    // the walk may also end on the skip loops; mark the last queued edge then
    if (traps > 0) expected_edges[expected_edges.size() - 1].quad_done = 1'b1;
  endtask

  task automatic accept_vertex(input vertex_t v);
    qts_pkg::corner_t c;
    c.x = v.x;
    c.y = v.y;
    c.z = scaled_depth(v.z);
    c.s = v.s;
    corner_store[corner_slot] = c;
    corner_written[corner_slot] = 1'b1;
    corner_slot = (corner_slot + 1) & 3;
    if (v.last) begin
      corner_slot = 0;
      quads_split++;
      split_into_edges();
    end
  endtask

  // drive one corner from the falling edge, hold until accepted
  task automatic send_vertex(input vertex_t v);
    int gap;
    gap = 0;
    if ((idle_mode == 1 && $urandom_range(99) < 49) || (idle_mode == 3 && $urandom_range(99) < 22))
      gap = $urandom_range(1, 6);
    repeat (gap) begin
      @(negedge clk_i);
      vtx.valid <= 1'b0;
    end
    @(negedge clk_i);
    vtx.valid <= 1'b1;
    vtx.vertex_x <= v.x;
    vtx.vertex_y <= v.y;
    vtx.vertex_z <= v.z;
    vtx.vertex_shade <= v.s;
    vtx.vertex_last <= v.last;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    accept_vertex(v);
    vertices_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    vtx.valid <= 1'b0;
  endtask

  // wait for every expected edge, then let a result-free split finish
  task automatic drain();
    drop_valid();
    while (expected_edges.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [qts_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qts_pkg::CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == qts_pkg::CFG_DEPTH_OFFSET) depth_offset = data;
    else depth_scale = data;
  endtask

  function automatic vertex_t rand_vertex(input logic [qts_pkg::YW-1:0] y, input logic last);
    vertex_t v;
    v.x = $urandom;
    v.y = y;
    v.z = $urandom;
    v.s = 16'($urandom);
    v.last = last;
    return v;
  endfunction

  // one random quad, mostly well formed with small heights, sometimes noise
  task automatic send_random_quad();
    int pick, n, span;
    logic [qts_pkg::YW-1:0] base;
    pick = $urandom_range(99);
    base = 16'($urandom);
    span = (pick < 10) ? 65535 : $urandom_range(0, 40);
    if (pick >= 85 && corner_written == 4'hF) begin
      // early last corner, or a run of corners with no last
      n = $urandom_range(1, 3);
      for (int i = 0; i < n; i++)
        send_vertex(rand_vertex(base + 16'($urandom_range(0, 40)), pick >= 93 && i == n - 1));
    end else begin
      for (int i = 0; i < 4; i++)
        send_vertex(rand_vertex((pick < 10) ? 16'($urandom) : base + 16'($urandom_range(0, span)),
                                i == 3));
    end
  endtask

  // receiver: ready at the falling edge, with an occasional long hold-off
  always @(negedge clk_i) begin
    int hold_left;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else if (idle_mode == 2) begin
      res.ready <= ($urandom_range(99) >= 49);
    end else if (idle_mode == 3) begin
      res.ready <= ($urandom_range(99) >= 22);
    end else begin
      res.ready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // compare each accepted edge with the oldest expectation
  always @(posedge clk_i) begin
    qts_pkg::result_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_edges.size() == 0) begin
        $display("%0t: unexpected edge: row %h kind %b", $time, res.row, res.edge_kind);
        errors++;
      end else begin
        e = expected_edges.pop_front();
        check_field("row", 32'(e.row), 32'(res.row));
        check_field("edge_kind", 32'(e.edge_kind), 32'(res.edge_kind));
        check_field("left_x", e.left_x, res.left_x);
        check_field("right_x", e.right_x, res.right_x);
        check_field("left_z", e.left_z, res.left_z);
        check_field("right_z", e.right_z, res.right_z);
        check_field("left_shade", 32'(e.left_shade), 32'(res.left_shade));
        check_field("right_shade", 32'(e.right_shade), 32'(res.right_shade));
        check_field("quad_done", 32'(e.quad_done), 32'(res.quad_done));
        edges_checked++;
      end
    end
  end

  // directed corners: rectangle, extremes, flat quad, concave loop, early last, diamond
  vertex_t corner_table[] = '{
    '{32'h0010_0000, 16'd10, 32'd1000, 16'h0100, 1'b0},
    '{32'h0050_0000, 16'd10, 32'd2000, 16'h0200, 1'b0},
    '{32'h0050_0000, 16'd40, 32'd3000, 16'h0300, 1'b0},
    '{32'h0010_0000, 16'd40, 32'd4000, 16'h0400, 1'b1},
    '{32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000, 1'b0},
    '{32'hFFFF_FFFF, 16'd100, 32'hFFFF_FFFF, 16'hFFFF, 1'b0},
    '{32'h8000_0000, 16'hFFFF, 32'h8000_0000, 16'hFF7F, 1'b0},
    '{32'h1234_5678, 16'd200, 32'h0000_0001, 16'h0080, 1'b1},
    '{32'h0001_0000, 16'd77, 32'd5, 16'h1000, 1'b0},
    '{32'h0002_0000, 16'd77, 32'd6, 16'h2000, 1'b0},
    '{32'h0003_0000, 16'd77, 32'd7, 16'h3000, 1'b0},
    '{32'h0004_0000, 16'd77, 32'd8, 16'h4000, 1'b1},
    '{32'h0010_0000, 16'd0, 32'd100, 16'h0A00, 1'b0},
    '{32'h0020_0000, 16'd50, 32'd900, 16'h1400, 1'b0},
    '{32'h0018_0000, 16'd10, 32'd300, 16'hFFFF, 1'b0},
    '{32'h0008_0000, 16'd60, 32'd50, 16'h0000, 1'b1},
    '{32'h0030_0000, 16'd5, 32'd70, 16'h5000, 1'b1},
    '{32'h0032_0000, 16'd0, 32'd10, 16'h0800, 1'b0},
    '{32'h0064_0000, 16'd50, 32'd20, 16'h1000, 1'b0},
    '{32'h0032_0000, 16'd100, 32'd30, 16'h1800, 1'b0},
    '{32'h0000_0000, 16'd50, 32'd40, 16'h2000, 1'b1}
  };

  logic [qts_pkg::CFG_W-1:0] phase_offset[] = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1000, 32'd0};
  logic [qts_pkg::CFG_W-1:0] phase_scale[]  = '{32'h0001_0000, 32'hFFFF_FFFF, 32'd0,
                                                32'hFFFF_FFFF, 32'd1};

  // stimulus
  initial begin
    int start_items;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = qts_pkg::CFG_DEPTH_OFFSET;
    cfg_data_i = '0;
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.vertex_shade = '0;
    vtx.vertex_last = 1'b0;
    res.ready = 1'b0;
    corner_written = '0;
    corner_slot = 0;
    depth_offset = '0;
    depth_scale = qts_pkg::DEPTH_SCALE_RST;
    idle_mode = 0;
    long_hold_req = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings
    foreach (corner_table[i]) send_vertex(corner_table[i]);
    drain();

    // random phases, each under its own depth settings, cycling through the idling patterns
    for (int p = 0; p < 6; p++) begin
      if (p < 5) begin
        write_reg(qts_pkg::CFG_DEPTH_OFFSET, phase_offset[p]);
        write_reg(qts_pkg::CFG_DEPTH_SCALE, phase_scale[p]);
      end else begin
        write_reg(qts_pkg::CFG_DEPTH_OFFSET, $urandom_range(0, 32'h00FF_FFFF));
        write_reg(qts_pkg::CFG_DEPTH_SCALE, $urandom);
      end
      idle_mode = p % 4;
      start_items = vertices_sent;
      // back up the output while corners keep coming
      if (p == 1) long_hold_req = 1'b1;
      while (vertices_sent - start_items < ITEMS_PER_PHASE) begin
        send_random_quad();
        // pause now and then until every edge is out
        if (p == 2 && vertices_sent - start_items > 40 && vertices_sent - start_items < 45) begin
          drop_valid();
          while (expected_edges.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    $display("sent %0d corners forming %0d split requests, checked %0d trapezoid edges",
             vertices_sent, quads_split, edges_checked);
    $display("depth settings covered reset, zero and full scale, full offset; %0d errors",
             errors);
    if (errors == 0 && expected_edges.size() == 0) begin
      $display("quad_trapezoid_splitter_core_tb: PASS");
    end else begin
      $display("quad_trapezoid_splitter_core_tb: FAIL");
    end
    $finish;
  end

endmodule
